// File: rtl/core/relative_window_cluster_match_assert.svh
// ---------------------------------------------------------------------------
// relative window cluster match assertion macros
// shared property templates for the port checker
// ---------------------------------------------------------------------------
`ifndef RELATIVE_WINDOW_CLUSTER_MATCH_ASSERT_SVH
`define RELATIVE_WINDOW_CLUSTER_MATCH_ASSERT_SVH

// same-cycle implication
`define RWCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwcm same-cycle property failed");

// next-cycle implication
`define RWCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwcm next-cycle property failed");

`endif

// File: rtl/core/rwcm_pkg.sv
// ---------------------------------------------------------------------------
// rwcm_pkg
// shared constants and types of the relative window cluster match block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwcm_pkg;

    localparam int MAX_CLUSTERS = 256;
    localparam int ADDR_W       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
    localparam int DATA_W       = 32;
    localparam int ENTRY_W      = 2 * DATA_W;
    localparam int IDX_W        = 24;
    localparam int WIN_W        = 16;
    localparam int SHIFT        = 12;
    localparam int PROD_W       = WIN_W + DATA_W;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd2048;
    localparam logic [DATA_W-1:0] RATE_FLOOR   = 32'd16777;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              load_we;
        logic              query_start;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
    } rwcm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } rwcm_status_t;

endpackage

// File: rtl/core/rwcm_ram.sv
// ---------------------------------------------------------------------------
// rwcm_ram
// generic single-port-write, registered-read memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwcm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rwcm_ctrl.sv
// ---------------------------------------------------------------------------
// rwcm_ctrl
// request sequencer: cluster count, scan address and result strobe
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwcm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  kind,
    output logic                  busy,
    output logic                  done,
    output rwcm_pkg::rwcm_cmd_t   cmd,
    input  rwcm_pkg::rwcm_status_t status
);

    import rwcm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic accept;
    logic load_ok;
    logic last_addr;

    assign accept    = start && !busy_reg && (state_reg == ST_IDLE);
    assign load_ok   = accept && (kind == KIND_LOAD) && (count_reg < CNT_W'(MAX_CLUSTERS));
    assign last_addr = (CNT_W'(addr_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (accept && (kind == KIND_QUERY))
                begin
                    addr_next = '0;
                    busy_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            addr_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd.load_we     = load_ok;
        cmd.query_start = accept && (kind == KIND_QUERY);
        cmd.rd_en       = (state_reg == ST_SCAN);
        cmd.addr        = load_ok ? count_reg[ADDR_W-1:0] : addr_reg;
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/rwcm_datapath.sv
// ---------------------------------------------------------------------------
// rwcm_datapath
// cluster store, window register and pipelined window compare
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwcm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rwcm_pkg::WIN_W-1:0]    cfg_wdata,
    input  logic [rwcm_pkg::DATA_W-1:0]   radius,
    input  logic signed [rwcm_pkg::DATA_W-1:0] radial_rate,
    input  logic [rwcm_pkg::IDX_W-1:0]    hyp_index,
    input  rwcm_pkg::rwcm_cmd_t           cmd,
    output rwcm_pkg::rwcm_status_t        status,
    output logic [rwcm_pkg::IDX_W-1:0]    out_index,
    output logic                          active
);

    import rwcm_pkg::*;

    logic [WIN_W-1:0]  window_reg;
    logic [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0] v_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [ENTRY_W-1:0] rd_data;

    logic v1_reg, v2_reg, v3_reg;
    logic hit_reg;

    // stage 1 results
    logic [DATA_W-1:0] dr_s1_reg, rc_s1_reg, scale_s1_reg;
    logic [DATA_W:0]   dv_s1_reg;
    // stage 2 results
    logic [DATA_W-1:0] dr_s2_reg;
    logic [DATA_W:0]   dv_s2_reg;
    logic [PROD_W-1:0] pr_s2_reg, pv_s2_reg;

    logic [DATA_W-1:0]        rc;
    logic signed [DATA_W:0]   dr_diff, dv_diff, vc_ext;
    logic [DATA_W:0]          dr_abs, dv_abs, vc_abs;
    logic [DATA_W-1:0]        scale;
    logic                     pass_r, pass_v;

    rwcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.addr),
        .wdata ({radial_rate, radius}),
        .re    (cmd.rd_en),
        .raddr (cmd.addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            r_reg   <= radius;
            v_reg   <= radial_rate;
            idx_reg <= hyp_index;
        end
    end

    always_comb
    begin
        rc      = rd_data[DATA_W-1:0];
        vc_ext  = {rd_data[ENTRY_W-1], rd_data[ENTRY_W-1:DATA_W]};
        dr_diff = $signed({1'b0, r_reg}) - $signed({1'b0, rc});
        dv_diff = $signed({v_reg[DATA_W-1], v_reg}) - vc_ext;
        dr_abs  = dr_diff[DATA_W] ? (DATA_W+1)'(-dr_diff) : dr_diff;
        dv_abs  = dv_diff[DATA_W] ? (DATA_W+1)'(-dv_diff) : dv_diff;
        vc_abs  = vc_ext[DATA_W] ? (DATA_W+1)'(-vc_ext) : vc_ext;
        scale   = (vc_abs > {1'b0, RATE_FLOOR}) ? vc_abs[DATA_W-1:0] : RATE_FLOOR;
    end

    always_ff @(posedge clk)
    begin
        dr_s1_reg    <= dr_abs[DATA_W-1:0];
        dv_s1_reg    <= dv_abs;
        rc_s1_reg    <= rc;
        scale_s1_reg <= scale;

        dr_s2_reg <= dr_s1_reg;
        dv_s2_reg <= dv_s1_reg;
        pr_s2_reg <= PROD_W'(window_reg) * PROD_W'(rc_s1_reg);
        pv_s2_reg <= PROD_W'(window_reg) * PROD_W'(scale_s1_reg);
    end

    assign pass_r = PROD_W'({dr_s2_reg, {SHIFT{1'b0}}}) < pr_s2_reg;
    assign pass_v = PROD_W'({dv_s2_reg, {SHIFT{1'b0}}}) < pv_s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.query_start)
            begin
                hit_reg <= 1'b0;
            end
            else if (v3_reg && pass_r && pass_v)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign out_index        = idx_reg;
    assign active           = hit_reg;

endmodule

// File: rtl/core/relative_window_cluster_match.sv
// ---------------------------------------------------------------------------
// relative_window_cluster_match
// stores cluster centres and flags query hypotheses that fall in the window
// ---------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low
//   kind low loads a cluster centre (radius, radial_rate) into the next free
//   slot; loads past the store capacity are dropped; a load gives no result
//   and leaves busy low, so requests may follow every cycle
//   kind high queries a hypothesis; busy rises and the stored clusters are
//   read back one per cycle from the store memory through a four-stage
//   compare pipeline (read, difference, multiply, compare)
//   a query keeps busy high until its last stored cluster has left the compare
//   pipeline, or on an empty store passes straight through drain; done pulses for
//   one cycle with out_index and active as busy falls
//   cfg_we writes window (Q4.12); the user must write it only while idle, as
//   the block does not enforce this; reset clears the cluster count, sets window
//   to 0.5 and drops any query in flight; store contents need no clearing
//   the result is shown for one cycle only; the receiver cannot stall it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module relative_window_cluster_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [rwcm_pkg::DATA_W-1:0]        radius,
    input  logic signed [rwcm_pkg::DATA_W-1:0] radial_rate,
    input  logic [rwcm_pkg::IDX_W-1:0]         hyp_index,
    input  logic                               cfg_we,
    input  logic [rwcm_pkg::WIN_W-1:0]         cfg_wdata,
    output logic                               done,
    output logic [rwcm_pkg::IDX_W-1:0]         out_index,
    output logic                               active
);

    import rwcm_pkg::*;

    rwcm_cmd_t    cmd;
    rwcm_status_t status;

    rwcm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    rwcm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .radius      (radius),
        .radial_rate (radial_rate),
        .hyp_index   (hyp_index),
        .cmd         (cmd),
        .status      (status),
        .out_index   (out_index),
        .active      (active)
    );

endmodule

// File: rtl/core/rwcm_checker.sv
// ---------------------------------------------------------------------------
// rwcm_checker
// port-level properties of the cluster match request and result sequence
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "relative_window_cluster_match_assert.svh"

module rwcm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic kind,
    input logic done
);

    import rwcm_pkg::*;

    `RWCM_ASSERT_NEXT(a_load_no_result, clk, rst_n, start && !busy && (kind == KIND_LOAD), !done)
    `RWCM_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (kind == KIND_QUERY), busy)
    `RWCM_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `RWCM_ASSERT_SAME(a_busy_end_done, clk, rst_n, $fell(busy), done)
    `RWCM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

endmodule

bind relative_window_cluster_match rwcm_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .done  (done)
);

// File: verif/tb_relative_window_cluster_match.sv
// ---------------------------------------------------------------------------
// tb_relative_window_cluster_match
// loads cluster centres and sends hypothesis queries through the start/busy
// request port; a local predictor of the store and window tests gives the
// expected index and active flag of each query when its request is taken;
// each done pulse is checked in order against that prediction; zero, full
// scale and random window settings and a full store are covered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_relative_window_cluster_match;

    import rwcm_pkg::*;

    typedef struct {
        logic              kind;
        logic [DATA_W-1:0] radius;
        logic [DATA_W-1:0] rate;
        logic [IDX_W-1:0]  index;
        int                gap;
    } cluster_req_t;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             active;
    } match_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    logic                     kind        = KIND_LOAD;
    logic [DATA_W-1:0]        radius      = '0;
    logic signed [DATA_W-1:0] radial_rate = '0;
    logic [IDX_W-1:0]         hyp_index   = '0;
    logic                     cfg_we      = 1'b0;
    logic [WIN_W-1:0]         cfg_wdata   = '0;
    logic                     done;
    logic [IDX_W-1:0]         out_index;
    logic                     active;

    cluster_req_t  pending_reqs [$];
    match_result_t expected_matches [$];

    // predictor state
    logic [WIN_W-1:0]  window_model;
    logic [DATA_W-1:0] centre_radius [MAX_CLUSTERS];
    logic [DATA_W-1:0] centre_rate [MAX_CLUSTERS];
    int                centre_count;

    // stimulus side view of the store
    logic [DATA_W-1:0] sent_radius [$];
    logic [DATA_W-1:0] sent_rate [$];
    int                loads_sent = 0;
    logic [WIN_W-1:0]  cur_window = WINDOW_RESET;
    logic              no_idle    = 1'b0;

    logic req_taken;
    int   gap_left   = 0;
    int   fail_count = 0;
    int   shown      = 0;

    always #5 clk = ~clk;

    relative_window_cluster_match i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .radius      (radius),
        .radial_rate (radial_rate),
        .hyp_index   (hyp_index),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .out_index   (out_index),
        .active      (active)
    );

    function automatic logic near_centre(input logic [DATA_W-1:0] r,
                                         input logic [DATA_W-1:0] v,
                                         input logic [DATA_W-1:0] rc,
                                         input logic [DATA_W-1:0] vc,
                                         input logic [WIN_W-1:0] w);
        longint dr;
        longint dv;
        longint vcs;
        longint scale;
        dr = longint'(r) - longint'(rc);
        if (dr < 0)
            dr = -dr;
        dr = dr << SHIFT;
        vcs = longint'($signed(vc));
        dv = longint'($signed(v)) - vcs;
        if (dv < 0)
            dv = -dv;
        dv = dv << SHIFT;
        scale = (vcs < 0) ? -vcs : vcs;
        if (scale < longint'(RATE_FLOOR))
            scale = longint'(RATE_FLOOR);
        return (dr < longint'(w) * longint'(rc)) && (dv < longint'(w) * scale);
    endfunction

    function automatic logic hits_any_cluster(input logic [DATA_W-1:0] r,
                                              input logic [DATA_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < centre_count; i++)
            if (near_centre(r, v, centre_radius[i], centre_rate[i], window_model))
                hit = 1'b1;
        return hit;
    endfunction

    // predictor and result check
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        match_result_t want;
        if (!rst_n)
        begin
            window_model = WINDOW_RESET;
            centre_count = 0;
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= start && !busy;
            if (cfg_we)
                window_model = cfg_wdata;
            if (done)
            begin
                if (expected_matches.size() == 0)
                begin
                    if (shown < 10)
                        $display("unexpected result: index %06h active %0b", out_index, active);
                    shown++;
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (out_index !== want.index || active !== want.active)
                    begin
                        if (shown < 10)
                            $display("mismatch: index exp %06h got %06h, active exp %0b got %0b",
                                     want.index, out_index, want.active, active);
                        shown++;
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (kind == KIND_LOAD)
                begin
                    if (centre_count < MAX_CLUSTERS)
                    begin
                        centre_radius[centre_count] = radius;
                        centre_rate[centre_count]   = radial_rate;
                        centre_count++;
                    end
                end
                else
                begin
                    want.index  = hyp_index;
                    want.active = hits_any_cluster(radius, radial_rate);
                    expected_matches.push_back(want);
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin : drive_proc
        logic         start_nx;
        cluster_req_t req;
        start_nx = start;
        if (!rst_n)
            start_nx = 1'b0;
        else if (!start || req_taken)
        begin
            start_nx = 1'b0;
            if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (pending_reqs.size() > 0)
            begin
                req = pending_reqs.pop_front();
                kind        <= req.kind;
                radius      <= req.radius;
                radial_rate <= req.rate;
                hyp_index   <= req.index;
                gap_left    = req.gap;
                start_nx    = 1'b1;
            end
        end
        start <= start_nx;
    end

    function automatic int pick_gap();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic push_req(input logic k, input logic [DATA_W-1:0] r,
                            input logic [DATA_W-1:0] v, input logic [IDX_W-1:0] idx);
        cluster_req_t req;
        req.kind   = k;
        req.radius = r;
        req.rate   = v;
        req.index  = idx;
        req.gap    = pick_gap();
        pending_reqs.push_back(req);
        if (k == KIND_LOAD)
        begin
            loads_sent++;
            if (sent_radius.size() < MAX_CLUSTERS)
            begin
                sent_radius.push_back(r);
                sent_rate.push_back(v);
            end
        end
    endtask

    // distance around the window edge, often right at the limit
    function automatic longint spread(input longint lim);
        longint dmax;
        dmax = (lim > 0) ? ((lim - 1) >>> SHIFT) : 0;
        if ($urandom_range(0, 3) == 0)
            return dmax + longint'($urandom_range(0, 1));
        return (dmax * longint'($urandom_range(0, 1536))) / 1024;
    endfunction

    task automatic push_near_query();
        int     k;
        longint rc;
        longint vc;
        longint scale;
        longint rq;
        longint vq;
        k  = $urandom_range(0, sent_radius.size() - 1);
        rc = longint'(sent_radius[k]);
        vc = longint'($signed(sent_rate[k]));
        rq = spread(longint'(cur_window) * rc);
        rq = $urandom_range(0, 1) ? rc + rq : rc - rq;
        if (rq < 0)
            rq = 0;
        if (rq > 64'sh0_FFFF_FFFF)
            rq = 64'sh0_FFFF_FFFF;
        scale = (vc < 0) ? -vc : vc;
        if (scale < longint'(RATE_FLOOR))
            scale = longint'(RATE_FLOOR);
        vq = spread(longint'(cur_window) * scale);
        vq = $urandom_range(0, 1) ? vc + vq : vc - vq;
        if (vq < -64'sh8000_0000)
            vq = -64'sh8000_0000;
        if (vq > 64'sh7FFF_FFFF)
            vq = 64'sh7FFF_FFFF;
        push_req(KIND_QUERY, rq[31:0], vq[31:0], IDX_W'($urandom));
    endtask

    task automatic push_random_items(input int count);
        int                sel;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < ((loads_sent < MAX_CLUSTERS + 14) ? 55 : 5))
            begin
                sel = $urandom_range(0, 9);
                r = (sel == 0) ? '0 : (sel == 1) ? $urandom_range(0, 255) : $urandom;
                v = (sel > 6) ? $urandom_range(0, 33554) - 16777 : $urandom;
                push_req(KIND_LOAD, r, v, IDX_W'($urandom));
            end
            else if (sent_radius.size() > 0 && $urandom_range(0, 3) != 0)
                push_near_query();
            else
                push_req(KIND_QUERY, $urandom, $urandom, IDX_W'($urandom));
        end
    endtask

    task automatic wait_idle(input int limit_cycles);
        int n;
        n = 0;
        do
        begin
            @(posedge clk);
            #1;
            n++;
        end
        while (!(pending_reqs.size() == 0 && !start && expected_matches.size() == 0
                 && !busy) && n < limit_cycles);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_window = w;
    endtask

    initial
    begin : timeout_proc
        #9_000_000;
        $display("tb_relative_window_cluster_match: done, errors");
        $finish;
    end

    initial
    begin : stim_proc
        logic [WIN_W-1:0] windows [7];
        windows[0] = 16'd0;
        windows[1] = 16'hFFFF;
        windows[2] = 16'd1;
        windows[3] = WIN_W'($urandom_range(0, 65535));
        windows[4] = 16'd4096;
        windows[5] = WIN_W'($urandom_range(0, 65535));
        windows[6] = 16'd205;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // directed requests at the reset window of one half
        push_req(KIND_QUERY, 32'h0100_0000, 32'h0, 24'h000000);
        push_req(KIND_LOAD,  32'h0,         32'h0, 24'hFFFFFF);
        push_req(KIND_QUERY, 32'h0,         32'h0, 24'hFFFFFF);
        push_req(KIND_LOAD,  32'h0100_0000, 32'h0, 24'h000000);
        push_req(KIND_QUERY, 32'h0100_0000, 32'h0, 24'h000001);
        push_req(KIND_QUERY, 32'h017F_FFFF, 32'd8388, 24'h000002);
        push_req(KIND_QUERY, 32'h0180_0000, 32'd8388, 24'h000003);
        push_req(KIND_QUERY, 32'h017F_FFFF, 32'd8389, 24'h000004);
        push_req(KIND_QUERY, 32'h0080_0001, -32'sd8388, 24'h000005);
        push_req(KIND_LOAD,  32'hFFFF_FFFF, 32'h8000_0000, 24'h000000);
        push_req(KIND_QUERY, 32'hFFFF_FFFF, 32'h8000_0000, 24'h555555);
        push_req(KIND_QUERY, 32'h0,         32'h7FFF_FFFF, 24'hAAAAAA);
        push_req(KIND_LOAD,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'h000000);
        push_req(KIND_QUERY, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'h800000);
        push_req(KIND_QUERY, 32'hBFFF_FFFF, 32'hC000_0000, 24'h7FFFFF);
        push_req(KIND_QUERY, 32'h8000_0000, 32'h4000_0000, 24'hFFFFFF);
        push_random_items(80);
        wait_idle(100000);

        for (int p = 0; p < 7; p++)
        begin
            repeat (16) @(posedge clk);
            set_window(windows[p]);
            no_idle = p[0];
            @(posedge clk);
            #1;
            if (windows[p] == 16'd0)
                push_req(KIND_QUERY, 32'h0100_0000, 32'h0, 24'h123456);
            push_random_items(80);
            wait_idle(100000);
        end

        repeat (16) @(posedge clk);
        set_window(WINDOW_RESET);
        no_idle = 1'b0;
        @(posedge clk);
        #1;
        while (loads_sent < MAX_CLUSTERS + 4)
            push_req(KIND_LOAD, $urandom, $urandom, IDX_W'($urandom));
        push_random_items(20);
        wait_idle(100000);
        repeat (20) @(posedge clk);

        if (expected_matches.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("tb_relative_window_cluster_match: done, clean");
        else
            $display("tb_relative_window_cluster_match: done, errors");
        $finish;
    end

endmodule
